// ===== hw/rtl/qrs_pkg.sv =====
// ----------------------------------------------------------------------------
// qrs_pkg
// shared codes and widths for the quadratic root solver
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int ROOT_WIDTH = 48;

  typedef enum logic [1:0] {
    KIND_DOUBLE  = 2'd0,
    KIND_TWO     = 2'd1,
    KIND_COMPLEX = 2'd2,
    KIND_DEGEN   = 2'd3
  } root_kind_t;

endpackage

// ===== hw/rtl/qrs_coef_if.sv =====
// ----------------------------------------------------------------------------
// qrs_coef_if
// request channel carrying one coefficient set a, b, c
// ----------------------------------------------------------------------------
interface qrs_coef_if #(
  parameter int COEF_WIDTH = 24
);
  logic                         valid;
  logic                         ready;
  logic signed [COEF_WIDTH-1:0] coef_quadratic;
  logic signed [COEF_WIDTH-1:0] coef_linear;
  logic signed [COEF_WIDTH-1:0] coef_constant;

  modport source (output valid, coef_quadratic, coef_linear, coef_constant, input ready);
  modport sink   (input valid, coef_quadratic, coef_linear, coef_constant, output ready);
endinterface

// ===== hw/rtl/qrs_root_if.sv =====
// ----------------------------------------------------------------------------
// qrs_root_if
// result channel carrying the root kind, both roots and the discriminant
// ----------------------------------------------------------------------------
interface qrs_root_if #(
  parameter int DISC_WIDTH = 50
);
  import qrs_pkg::*;
  logic                         valid;
  logic                         ready;
  root_kind_t                   root_kind;
  logic signed [ROOT_WIDTH-1:0] first_root;
  logic signed [ROOT_WIDTH-1:0] second_root;
  logic signed [DISC_WIDTH-1:0] discriminant;
  logic                         saturated;

  modport source (output valid, root_kind, first_root, second_root, discriminant, saturated,
                  input ready);
  modport sink   (input valid, root_kind, first_root, second_root, discriminant, saturated,
                  output ready);
endinterface

// ===== hw/rtl/quadratic_root_solver.sv =====
// ----------------------------------------------------------------------------
// quadratic_root_solver
// pipelined roots of a*x^2 + b*x + c in fixed point
// ----------------------------------------------------------------------------
// Accepts one coefficient set per cycle while no result waits to be taken
// and returns one result per set, in order. The stages are, in order: the
// multiply stage for the two multiplies, the discriminant register, the
// stages of the digit-by-digit square root, the register that forms the
// numerators and |2a|, the stages of the two restoring dividers that run
// side by side, and the sign and clamp register. The whole pipeline holds
// while a result waits to be taken, so coefs.ready follows roots.ready
// whenever a result is pending.
module quadratic_root_solver
  import qrs_pkg::*;
#(
  parameter int COEF_WIDTH = 24,
  parameter int FRAC_BITS  = 12
) (
  input  logic       clk,
  input  logic       rst,
  qrs_coef_if.sink   coefs,
  qrs_root_if.source roots
);

  localparam int DW   = 2*COEF_WIDTH + 2;
  localparam int RW   = DW/2;
  localparam int RMW  = RW + 2;
  localparam int NW   = COEF_WIDTH + 3;
  localparam int MW   = COEF_WIDTH + 2;
  localparam int DVW  = MW + FRAC_BITS;
  localparam int EW   = ((DVW > ROOT_WIDTH) ? DVW : ROOT_WIDTH) + 1;
  localparam int CW   = COEF_WIDTH;

  logic adv;
  assign adv = !roots.valid || roots.ready;
  assign coefs.ready = adv;

  // multiply stage
  logic                  m_v;
  logic signed [CW-1:0]  m_a, m_b;
  logic signed [2*CW-1:0] m_bb, m_ac;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
    end else if (adv) begin
      m_v <= coefs.valid;
    end
    if (adv) begin
      m_a  <= coefs.coef_quadratic;
      m_b  <= coefs.coef_linear;
      m_bb <= coefs.coef_linear * coefs.coef_linear;
      m_ac <= coefs.coef_quadratic * coefs.coef_constant;
    end
  end

  // square root stages, index 0 holds the discriminant
  logic                 sq_v    [RW+1];
  logic signed [CW-1:0] sq_a    [RW+1];
  logic signed [CW-1:0] sq_b    [RW+1];
  logic signed [DW-1:0] sq_d    [RW+1];
  logic [DW-1:0]        sq_rad  [RW+1];
  logic [RMW-1:0]       sq_rem  [RW+1];
  logic [RW-1:0]        sq_root [RW+1];

  logic [DW-1:0]        rad_next  [RW];
  logic [RMW-1:0]       rem_next  [RW];
  logic [RW-1:0]        root_next [RW];
  logic signed [DW-1:0] d_calc;

  always_comb begin
    logic [RMW+1:0] cat;
    logic [RMW+1:0] trial;
    d_calc = {{2{m_bb[2*CW-1]}}, m_bb} - ({{2{m_ac[2*CW-1]}}, m_ac} <<< 2);
    for (int k = 0; k < RW; k++) begin
      cat   = {sq_rem[k], sq_rad[k][DW-1:DW-2]};
      trial = {2'b00, sq_root[k], 2'b01};
      rad_next[k] = sq_rad[k] << 2;
      if (cat >= trial) begin
        rem_next[k]  = RMW'(cat - trial);
        root_next[k] = {sq_root[k][RW-2:0], 1'b1};
      end else begin
        rem_next[k]  = RMW'(cat);
        root_next[k] = {sq_root[k][RW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= RW; k++) sq_v[k] <= 1'b0;
    end else if (adv) begin
      sq_v[0] <= m_v;
      for (int k = 0; k < RW; k++) sq_v[k+1] <= sq_v[k];
    end
    if (adv) begin
      sq_a[0]    <= m_a;
      sq_b[0]    <= m_b;
      sq_d[0]    <= d_calc;
      sq_rad[0]  <= d_calc[DW-1] ? DW'(-d_calc) : DW'(d_calc);
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      for (int k = 0; k < RW; k++) begin
        sq_a[k+1]    <= sq_a[k];
        sq_b[k+1]    <= sq_b[k];
        sq_d[k+1]    <= sq_d[k];
        sq_rad[k+1]  <= rad_next[k];
        sq_rem[k+1]  <= rem_next[k];
        sq_root[k+1] <= root_next[k];
      end
    end
  end

  // numerators and shared denominator magnitude |2a|
  logic signed [NW-1:0] nb, ns, n1, n2;
  logic                 dneg, aneg, neg1_calc, neg2_calc;
  logic [MW-1:0]        n1_mag, n2_mag, den_mag;
  root_kind_t           kind_calc;

  always_comb begin
    logic signed [DW-1:0] d;
    d    = sq_d[RW];
    dneg = d[DW-1];
    aneg = sq_a[RW][CW-1];
    nb   = -NW'(sq_b[RW]);
    ns   = NW'(sq_root[RW]);
    n1   = dneg ? nb : nb + ns;
    n2   = dneg ? ns : nb - ns;
    n1_mag  = n1[NW-1] ? MW'(-n1) : MW'(n1);
    n2_mag  = n2[NW-1] ? MW'(-n2) : MW'(n2);
    den_mag = aneg ? MW'(-(NW'(sq_a[RW]) <<< 1)) : MW'(NW'(sq_a[RW]) <<< 1);
    neg1_calc = (n1[NW-1] != aneg) && (n1 != '0);
    neg2_calc = !dneg && (n2[NW-1] != aneg) && (n2 != '0);
    priority if (sq_a[RW] == '0) begin
      kind_calc = KIND_DEGEN;
    end else if (d == '0) begin
      kind_calc = KIND_DOUBLE;
    end else if (!dneg) begin
      kind_calc = KIND_TWO;
    end else begin
      kind_calc = KIND_COMPLEX;
    end
  end

  // restoring divider stages, both quotients in parallel
  logic                 dv_v    [DVW+1];
  root_kind_t           dv_kind [DVW+1];
  logic                 dv_neg1 [DVW+1];
  logic                 dv_neg2 [DVW+1];
  logic [MW-1:0]        dv_den  [DVW+1];
  logic signed [DW-1:0] dv_d    [DVW+1];
  logic [DVW-1:0]       dv_x1   [DVW+1];
  logic [DVW-1:0]       dv_x2   [DVW+1];
  logic [MW:0]          dv_r1   [DVW+1];
  logic [MW:0]          dv_r2   [DVW+1];
  logic [DVW-1:0]       dv_q1   [DVW+1];
  logic [DVW-1:0]       dv_q2   [DVW+1];

  logic [MW:0]    r1_next [DVW];
  logic [MW:0]    r2_next [DVW];
  logic [DVW-1:0] q1_next [DVW];
  logic [DVW-1:0] q2_next [DVW];

  always_comb begin
    logic [MW+1:0] c1, c2, dn;
    for (int k = 0; k < DVW; k++) begin
      dn = (MW+2)'(dv_den[k]);
      c1 = {dv_r1[k], dv_x1[k][DVW-1]};
      c2 = {dv_r2[k], dv_x2[k][DVW-1]};
      if (c1 >= dn) begin
        r1_next[k] = (MW+1)'(c1 - dn);
        q1_next[k] = {dv_q1[k][DVW-2:0], 1'b1};
      end else begin
        r1_next[k] = (MW+1)'(c1);
        q1_next[k] = {dv_q1[k][DVW-2:0], 1'b0};
      end
      if (c2 >= dn) begin
        r2_next[k] = (MW+1)'(c2 - dn);
        q2_next[k] = {dv_q2[k][DVW-2:0], 1'b1};
      end else begin
        r2_next[k] = (MW+1)'(c2);
        q2_next[k] = {dv_q2[k][DVW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DVW; k++) dv_v[k] <= 1'b0;
    end else if (adv) begin
      dv_v[0] <= sq_v[RW];
      for (int k = 0; k < DVW; k++) dv_v[k+1] <= dv_v[k];
    end
    if (adv) begin
      dv_kind[0] <= kind_calc;
      dv_neg1[0] <= neg1_calc;
      dv_neg2[0] <= neg2_calc;
      dv_den[0]  <= den_mag;
      dv_d[0]    <= sq_d[RW];
      dv_x1[0]   <= DVW'(n1_mag) << FRAC_BITS;
      dv_x2[0]   <= DVW'(n2_mag) << FRAC_BITS;
      dv_r1[0]   <= '0;
      dv_r2[0]   <= '0;
      dv_q1[0]   <= '0;
      dv_q2[0]   <= '0;
      for (int k = 0; k < DVW; k++) begin
        dv_kind[k+1] <= dv_kind[k];
        dv_neg1[k+1] <= dv_neg1[k];
        dv_neg2[k+1] <= dv_neg2[k];
        dv_den[k+1]  <= dv_den[k];
        dv_d[k+1]    <= dv_d[k];
        dv_x1[k+1]   <= dv_x1[k] << 1;
        dv_x2[k+1]   <= dv_x2[k] << 1;
        dv_r1[k+1]   <= r1_next[k];
        dv_r2[k+1]   <= r2_next[k];
        dv_q1[k+1]   <= q1_next[k];
        dv_q2[k+1]   <= q2_next[k];
      end
    end
  end

  // sign and clamp to the root range
  function automatic logic [ROOT_WIDTH:0] clamp_root(input logic [DVW-1:0] q, input logic neg);
    logic [EW-1:0] qe, maxp, qc;
    qe   = EW'(q);
    maxp = (EW'(1) << (ROOT_WIDTH-1)) - EW'(1);
    qc   = qe;
    clamp_root[ROOT_WIDTH] = 1'b0;
    if (!neg && qe > maxp) begin
      qc = maxp;
      clamp_root[ROOT_WIDTH] = 1'b1;
    end else if (neg && qe > maxp + EW'(1)) begin
      qc = maxp + EW'(1);
      clamp_root[ROOT_WIDTH] = 1'b1;
    end
    clamp_root[ROOT_WIDTH-1:0] = neg ? ROOT_WIDTH'(-qc) : ROOT_WIDTH'(qc);
  endfunction

  logic [ROOT_WIDTH:0] c1_root, c2_root;
  assign c1_root = clamp_root(dv_q1[DVW], dv_neg1[DVW]);
  assign c2_root = clamp_root(dv_q2[DVW], dv_neg2[DVW]);

  always_ff @(posedge clk) begin
    if (rst) begin
      roots.valid <= 1'b0;
    end else if (adv) begin
      roots.valid <= dv_v[DVW];
    end
    if (adv) begin
      roots.root_kind    <= dv_kind[DVW];
      roots.discriminant <= dv_d[DVW];
      if (dv_kind[DVW] == KIND_DEGEN) begin
        roots.first_root  <= '0;
        roots.second_root <= '0;
        roots.saturated   <= 1'b0;
      end else begin
        roots.first_root  <= c1_root[ROOT_WIDTH-1:0];
        roots.second_root <= c2_root[ROOT_WIDTH-1:0];
        roots.saturated   <= c1_root[ROOT_WIDTH] | c2_root[ROOT_WIDTH];
      end
    end
  end

endmodule
